// ===== rtl/gpi_pkg.sv =====
`timescale 1ns / 1ps

package gpi_pkg;

	localparam int DW   = 48;
	localparam int DDW  = DW + 1;
	localparam int LW   = 9;
	localparam int DIG  = 16;
	localparam int MW   = 64;
	localparam int NDIG = MW / DIG;
	localparam int DGW  = $clog2(NDIG);
	localparam int PW   = 2 * DW + 1;
	localparam int NW   = PW + 1;
	localparam int NCW  = $clog2(NW);

	typedef logic signed [DW-1:0] num_t;
	typedef logic [2:0]           act_t;

	localparam act_t ACT_WRITE  = 3'd0;
	localparam act_t ACT_SETV   = 3'd1;
	localparam act_t ACT_READ   = 3'd2;
	localparam act_t ACT_READP  = 3'd3;
	localparam act_t ACT_INTERP = 3'd4;

	localparam logic       REG_ORDER = 1'b0;
	localparam logic [3:0] ORDER_RST = 4'd4;

	localparam num_t POS_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam num_t NEG_MAX = {1'b1, {(DW-1){1'b0}}};

	function automatic logic [DW-1:0] mag48(input logic signed [DW-1:0] a);
		mag48 = a[DW-1] ? DW'(-a) : DW'(a);
	endfunction

	function automatic logic [DDW-1:0] mag49(input logic signed [DDW-1:0] a);
		mag49 = a[DDW-1] ? DDW'(-a) : DDW'(a);
	endfunction

	function automatic logic [NW-1:0] magnw(input logic signed [NW-1:0] a);
		magnw = a[NW-1] ? NW'(-a) : NW'(a);
	endfunction

endpackage

// ===== rtl/gpi_ram.sv =====
`timescale 1ns / 1ps

module gpi_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/grid_polynomial_interpolator.sv =====
`timescale 1ns / 1ps
// Each position lookup is a binary search of n steps, n at most ceil(log2(GRID_POINTS+1)).
// Interpolation searches for the query, loads a window of k points (one search each for
// their values), then runs k*(k-1)/2 Neville steps, each with two 4-digit multiplies and a
// divide; a step whose divisor is zero skips both and leaves its entry unchanged.
// One item in flight; the next is taken while a finished result waits.
// Reset clears control and sets interp_order to 4; table contents stay undefined until written.

module grid_polynomial_interpolator import gpi_pkg::*; #(
	parameter int GRID_POINTS = 256,
	parameter int MAX_ORDER   = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        action,
	input  logic [7:0]        point_index,
	input  logic signed [DW-1:0] position,
	input  logic signed [DW-1:0] point_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [DW-1:0] result_value,
	output logic [LW-1:0]     location,
	output logic              status
);

	localparam int IW   = $clog2(GRID_POINTS);
	localparam int KMAX = (MAX_ORDER < GRID_POINTS) ? MAX_ORDER : GRID_POINTS;
	localparam int KW   = $clog2(KMAX + 1);
	localparam int XW   = $clog2(KMAX);
	localparam logic [IW:0] GP_L = (IW+1)'(GRID_POINTS);

	typedef enum logic [4:0] {
		S_IDLE, S_DEC, S_BS, S_BS_CMP, S_RD_WAIT, S_WIN_POS, S_WIN_POSW, S_WIN_VALW,
		S_NV_A, S_NV_B, S_NV_C, S_MUL, S_ACC, S_DIV, S_NV_WB, S_NV_FIN, S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic [3:0] order_q;

	act_t   act_q;
	logic [7:0] idx_q;
	num_t   x_q, v_q, key_q, res_q;
	logic [LW-1:0] loc_q;
	logic   stat_q, win_q;
	logic [IW:0] lo_q, hi_q;
	logic [IW-1:0] mid_q, start_q;
	logic [KW-1:0] k_q;
	logic [XW-1:0] wi_q, ni_q, nm_q;
	num_t   xs_q [KMAX];
	num_t   ps_q [KMAX];
	num_t   xi_q, xm_q, pa_q, pb_q;
	logic signed [DDW-1:0] den_q;
	logic [DW-1:0] mc_q;
	logic [MW-1:0] mp_q;
	logic   pneg_q, pass_q, rneg_q;
	logic [DGW-1:0] dig_q;
	logic [PW-1:0] prod_q;
	logic signed [NW-1:0] acc_q;
	logic [NW-1:0] dm_q, qt_q;
	logic [DDW-1:0] d_q, rem_q;
	logic [NCW-1:0] dc_q;
	num_t   res_out_q;
	logic [LW-1:0] loc_out_q;
	logic   stat_out_q;

	logic pos_we, val_we;
	logic [IW-1:0] pos_raddr, val_raddr, val_waddr, idx_w, lo_idx, mid_c, widx_c, start_c;
	num_t pos_rd, val_rd, val_wdata, xs_rd, ps_rd, sat_c;
	logic [IW+1:0] sum_c;
	logic bs_done, idx_ok, lo_ok, out_free, nv_last, nv_inc_i;
	logic [KW-1:0] k_c, half_c, tail_c;
	logic [IW:0] c1_c, c2_c;
	logic [XW-1:0] xa_c, pa_c;
	logic signed [DDW-1:0] a_c, b_c, den_c;
	logic [MW-1:0] pp_c;
	logic signed [NW-1:0] acc_sum_c;
	logic [DDW:0] r_c;

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_ORDER) ? {28'd0, order_q} : 32'd0;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign result_value = res_out_q;
	assign location     = loc_out_q;
	assign status       = stat_out_q;

	assign sum_c   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_c   = sum_c[IW:1];
	assign bs_done = !(lo_q < hi_q);
	assign lo_ok   = lo_q < GP_L;
	assign lo_idx  = lo_q[IW-1:0];
	assign idx_ok  = 32'(idx_q) < GRID_POINTS;
	assign idx_w   = IW'(idx_q);
	assign widx_c  = start_q + IW'(wi_q);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		if (order_q == 4'd0)
			k_c = KW'(1);
		else if (32'(order_q) > KMAX)
			k_c = KW'(KMAX);
		else
			k_c = KW'(order_q);
		half_c = k_c >> 1;
		tail_c = k_c - half_c;
		c1_c = (lo_q < (IW+1)'(half_c)) ? (IW+1)'(half_c) : lo_q;
		c2_c = ((GP_L - c1_c) < (IW+1)'(tail_c)) ? GP_L - (IW+1)'(tail_c) : c1_c;
		start_c = IW'(c2_c - (IW+1)'(half_c));
	end

	assign xa_c  = (state_q == S_NV_A) ? ni_q : XW'(ni_q + nm_q);
	assign pa_c  = (state_q == S_NV_A) ? ni_q : XW'(ni_q + XW'(1));
	assign xs_rd = xs_q[xa_c];
	assign ps_rd = ps_q[pa_c];

	assign a_c   = {x_q[DW-1], x_q} - {xm_q[DW-1], xm_q};
	assign b_c   = {xi_q[DW-1], xi_q} - {x_q[DW-1], x_q};
	assign den_c = {xi_q[DW-1], xi_q} - {xm_q[DW-1], xm_q};
	assign pp_c  = mc_q * mp_q[MW-1 -: DIG];
	assign acc_sum_c = acc_q + (pneg_q ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q}));
	assign r_c   = {rem_q, dm_q[NW-1]};

	always_comb begin
		if (rneg_q)
			sat_c = (qt_q > {{(NW-DW){1'b0}}, NEG_MAX}) ? NEG_MAX : num_t'(-qt_q[DW-1:0]);
		else
			sat_c = (qt_q > NW'(POS_MAX)) ? POS_MAX : num_t'(qt_q[DW-1:0]);
	end

	assign nv_inc_i = ((KW+1)'(ni_q) + (KW+1)'(nm_q) + (KW+1)'(1)) < (KW+1)'(k_q);
	assign nv_last  = !nv_inc_i && !(((KW+1)'(nm_q) + (KW+1)'(1)) < (KW+1)'(k_q));

	always_comb begin
		pos_we    = 1'b0;
		val_we    = 1'b0;
		pos_raddr = (state_q == S_WIN_POS) ? widx_c : mid_c;
		val_raddr = lo_idx;
		val_waddr = lo_idx;
		val_wdata = v_q;
		if (state_q == S_DEC) begin
			val_raddr = idx_w;
			val_waddr = idx_w;
			pos_we = (act_q == ACT_WRITE) && idx_ok;
			val_we = (act_q == ACT_WRITE) && idx_ok;
		end else if (state_q == S_BS && bs_done) begin
			if (win_q && !lo_ok)
				val_raddr = widx_c;
			val_we = !win_q && (act_q == ACT_SETV) && lo_ok;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (in_valid) state_d = S_DEC;
			S_DEC: begin
				case (act_q)
					ACT_READ:   state_d = idx_ok ? S_RD_WAIT : S_DONE;
					ACT_SETV, ACT_READP, ACT_INTERP: state_d = S_BS;
					default:    state_d = S_DONE;
				endcase
			end
			S_BS: begin
				if (!bs_done)
					state_d = S_BS_CMP;
				else if (win_q)
					state_d = S_WIN_VALW;
				else begin
					case (act_q)
						ACT_READP:  state_d = lo_ok ? S_RD_WAIT : S_DONE;
						ACT_INTERP: state_d = S_WIN_POS;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_BS_CMP:   state_d = S_BS;
			S_RD_WAIT:  state_d = S_DONE;
			S_WIN_POS:  state_d = S_WIN_POSW;
			S_WIN_POSW: state_d = S_BS;
			S_WIN_VALW: begin
				if ((KW'(wi_q) + KW'(1)) == k_q)
					state_d = (k_q == KW'(1)) ? S_NV_FIN : S_NV_A;
				else
					state_d = S_WIN_POS;
			end
			S_NV_A:     state_d = S_NV_B;
			S_NV_B:     state_d = S_NV_C;
			S_NV_C: begin
				if (den_c != '0)
					state_d = S_MUL;
				else
					state_d = nv_last ? S_NV_FIN : S_NV_A;
			end
			S_MUL:      if (dig_q == DGW'(NDIG - 1)) state_d = S_ACC;
			S_ACC:      state_d = pass_q ? S_DIV : S_MUL;
			S_DIV:      if (dc_q == NCW'(NW - 1)) state_d = S_NV_WB;
			S_NV_WB:    state_d = nv_last ? S_NV_FIN : S_NV_A;
			S_NV_FIN:   state_d = S_DONE;
			S_DONE:     if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			order_q     <= ORDER_RST;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && paddr[2] == REG_ORDER)
				order_q <= pwdata[3:0];
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					act_q  <= action;
					idx_q  <= point_index;
					x_q    <= position;
					v_q    <= point_value;
					key_q  <= position;
					lo_q   <= '0;
					hi_q   <= GP_L;
					win_q  <= 1'b0;
					res_q  <= '0;
					loc_q  <= '0;
					stat_q <= 1'b0;
				end
			end
			S_DEC: begin
				if (act_q == ACT_WRITE || act_q == ACT_READ) begin
					loc_q  <= LW'(idx_q);
					stat_q <= !idx_ok;
				end
			end
			S_BS: begin
				if (!bs_done)
					mid_q <= mid_c;
				else if (!win_q) begin
					loc_q <= LW'(lo_q);
					if (act_q == ACT_SETV || act_q == ACT_READP)
						stat_q <= !lo_ok;
					start_q <= start_c;
					k_q     <= k_c;
					wi_q    <= '0;
				end
			end
			S_BS_CMP: begin
				if (num_t'(pos_rd) < key_q)
					lo_q <= {1'b0, mid_q} + (IW+1)'(1);
				else
					hi_q <= {1'b0, mid_q};
			end
			S_RD_WAIT: res_q <= val_rd;
			S_WIN_POSW: begin
				xs_q[wi_q] <= pos_rd;
				key_q <= pos_rd;
				lo_q  <= '0;
				hi_q  <= GP_L;
				win_q <= 1'b1;
			end
			S_WIN_VALW: begin
				ps_q[wi_q] <= val_rd;
				wi_q <= wi_q + XW'(1);
				ni_q <= '0;
				nm_q <= XW'(1);
			end
			S_NV_A: begin
				xi_q <= xs_rd;
				pa_q <= ps_rd;
			end
			S_NV_B: begin
				xm_q <= xs_rd;
				pb_q <= ps_rd;
			end
			S_NV_C: begin
				den_q  <= den_c;
				acc_q  <= '0;
				prod_q <= '0;
				mc_q   <= mag48(pa_q);
				mp_q   <= MW'(mag49(a_c));
				pneg_q <= pa_q[DW-1] ^ a_c[DDW-1];
				dig_q  <= '0;
				pass_q <= 1'b0;
				if (den_c == '0) begin
					if (nv_inc_i)
						ni_q <= ni_q + XW'(1);
					else begin
						ni_q <= '0;
						nm_q <= nm_q + XW'(1);
					end
				end
			end
			S_MUL: begin
				prod_q <= (prod_q << DIG) + PW'(pp_c);
				mp_q   <= mp_q << DIG;
				dig_q  <= dig_q + DGW'(1);
			end
			S_ACC: begin
				acc_q <= acc_sum_c;
				if (!pass_q) begin
					mc_q   <= mag48(pb_q);
					mp_q   <= MW'(mag49(b_c));
					pneg_q <= pb_q[DW-1] ^ b_c[DDW-1];
					prod_q <= '0;
					dig_q  <= '0;
					pass_q <= 1'b1;
				end else begin
					dm_q   <= magnw(acc_sum_c) + NW'(mag49(den_q) >> 1);
					d_q    <= mag49(den_q);
					rneg_q <= acc_sum_c[NW-1] ^ den_q[DDW-1];
					rem_q  <= '0;
					qt_q   <= '0;
					dc_q   <= '0;
				end
			end
			S_DIV: begin
				dm_q <= dm_q << 1;
				dc_q <= dc_q + NCW'(1);
				if (r_c >= {1'b0, d_q}) begin
					rem_q <= DDW'(r_c - {1'b0, d_q});
					qt_q  <= {qt_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= r_c[DDW-1:0];
					qt_q  <= {qt_q[NW-2:0], 1'b0};
				end
			end
			S_NV_WB: begin
				ps_q[ni_q] <= sat_c;
				if (nv_inc_i)
					ni_q <= ni_q + XW'(1);
				else begin
					ni_q <= '0;
					nm_q <= nm_q + XW'(1);
				end
			end
			S_NV_FIN: res_q <= ps_q[0];
			S_DONE: begin
				if (out_free) begin
					res_out_q  <= res_q;
					loc_out_q  <= loc_q;
					stat_out_q <= stat_q;
				end
			end
			default: ;
		endcase
	end

	gpi_ram #(.WIDTH(DW), .DEPTH(GRID_POINTS)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (idx_w),
		.wdata (x_q),
		.raddr (pos_raddr),
		.rdata (pos_rd)
	);

	gpi_ram #(.WIDTH(DW), .DEPTH(GRID_POINTS)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.raddr (val_raddr),
		.rdata (val_rd)
	);

	a_one_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transfer taken while busy");

	a_pos_write: assert property (@(posedge clk) disable iff (!arst_n)
		pos_we |-> act_q == ACT_WRITE)
		else $error("position table written by wrong action");

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> result_value == '0)
		else $error("flagged result carries a value");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> d_q != '0)
		else $error("divide by zero");

endmodule

// ===== dv/grid_polynomial_interpolator_test.sv =====
`timescale 1ns / 1ps

module grid_polynomial_interpolator_test;
	import gpi_pkg::*;

	localparam int NPTS = 256;
	localparam int MAXK = 8;
	localparam act_t ACT_BAD5 = 3'd5;
	localparam act_t ACT_BAD6 = 3'd6;
	localparam act_t ACT_BAD7 = 3'd7;

	typedef struct {
		num_t           value;
		logic [LW-1:0]  loc;
		logic           st;
	} reply_t;

	typedef struct {
		act_t       act;
		logic [7:0] idx;
		num_t       pos;
		num_t       val;
		bit         typed;
		reply_t     want;
	} row_t;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [2:0] action;
	logic [7:0] point_index;
	num_t position, point_value, result_value;
	logic [LW-1:0] location;
	logic status;

	grid_polynomial_interpolator dut (.*);

	num_t grid_pos [NPTS];
	num_t grid_val [NPTS];
	int unsigned order_reg;
	reply_t pending_q [$];
	row_t rows [$];
	int errors;
	int snd_idle, rcv_idle;
	bit hold_req;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#500ms;
		$display("grid_polynomial_interpolator regression: fail");
		$finish;
	end

	function automatic num_t fill_pos(int i);
		longint p;
		p = longint'(i - 128) * (64'sd1 <<< 24) + longint'(i) * i * 1024;
		return num_t'(p);
	endfunction

	function automatic int lbound(num_t x);
		int lo, hi, mid;
		lo = 0;
		hi = NPTS;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (grid_pos[mid] < x) lo = mid + 1;
			else hi = mid;
		end
		return lo;
	endfunction

	function automatic num_t div_round(logic signed [127:0] n, logic signed [63:0] den);
		logic [127:0] m, q;
		logic [127:0] d;
		bit neg;
		neg = n[127] ^ den[63];
		m = n[127] ? -n : n;
		d = den[63] ? 128'(-den) : 128'(den);
		m = m + (d >> 1);
		q = m / d;
		if (neg) begin
			if (q > 128'h8000_0000_0000) return NEG_MAX;
			return num_t'(-q);
		end
		if (q > 128'(POS_MAX)) return POS_MAX;
		return num_t'(q);
	endfunction

	function automatic num_t neville_eval(num_t q, int loc);
		num_t xs [MAXK];
		num_t ps [MAXK];
		int k, half, tail, c, start, v;
		logic signed [63:0] den;
		logic signed [127:0] ta, tb, pa, pb;
		k = int'(order_reg);
		if (k < 1) k = 1;
		if (k > MAXK) k = MAXK;
		half = k / 2;
		tail = half + k % 2;
		c = loc;
		if (c < half) c = half;
		if (NPTS - c < tail) c = NPTS - tail;
		start = c - half;
		for (int i = 0; i < k; i++) begin
			v = lbound(grid_pos[start + i]);
			if (v >= NPTS) v = start + i;
			xs[i] = grid_pos[start + i];
			ps[i] = grid_val[v];
		end
		for (int m = 1; m < k; m++)
			for (int i = 0; i + m < k; i++) begin
				den = 64'(xs[i]) - 64'(xs[i + m]);
				if (den != 0) begin
					ta = 128'(q) - 128'(xs[i + m]);
					tb = 128'(xs[i]) - 128'(q);
					pa = 128'(ps[i]);
					pb = 128'(ps[i + 1]);
					ps[i] = div_round(ta * pa + tb * pb, den);
				end
			end
		return ps[0];
	endfunction

	function automatic reply_t apply_item(act_t a, logic [7:0] idx, num_t p, num_t v);
		reply_t r;
		int loc;
		r = '{default: '0};
		case (a)
			ACT_WRITE: begin
				r.loc = LW'(idx);
				grid_pos[idx] = p;
				grid_val[idx] = v;
			end
			ACT_READ: begin
				r.loc = LW'(idx);
				r.value = grid_val[idx];
			end
			ACT_SETV, ACT_READP: begin
				loc = lbound(p);
				r.loc = LW'(loc);
				if (loc >= NPTS) r.st = 1'b1;
				else if (a == ACT_SETV) grid_val[loc] = v;
				else r.value = grid_val[loc];
			end
			ACT_INTERP: begin
				loc = lbound(p);
				r.loc = LW'(loc);
				r.value = neville_eval(p, loc);
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send(act_t a, logic [7:0] idx, num_t p, num_t v, bit typed, reply_t want);
		int gap;
		reply_t got;
		gap = 0;
		while ($urandom_range(99) < snd_idle && gap < 40) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		point_index <= idx;
		position <= p;
		point_value <= v;
		do @(posedge clk); while (!in_ready);
		got = apply_item(a, idx, p, v);
		pending_q.push_back(typed ? want : got);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_order(logic [3:0] k);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(REG_ORDER) << 2;
		pwdata <= 32'(k);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		order_reg = 32'(k);
	endtask

	function automatic num_t rnd48();
		return num_t'({$urandom, $urandom});
	endfunction

	function automatic num_t rnd_value();
		if ($urandom_range(9) == 0) return rnd48();
		return num_t'($signed(32'($urandom)) >>> $urandom_range(8, 0));
	endfunction

	function automatic num_t rnd_query();
		longint lo, span;
		if ($urandom_range(19) == 0) return rnd48();
		if ($urandom_range(4) == 0) return grid_pos[$urandom_range(NPTS - 1)];
		lo = longint'(fill_pos(0)) - (64'sd1 <<< 26);
		span = longint'(fill_pos(NPTS - 1)) + (64'sd1 <<< 26) - lo;
		return num_t'(lo + longint'({$urandom, $urandom} % span));
	endfunction

	task automatic random_item();
		int sel, i;
		longint lo, hi;
		logic [7:0] idx;
		num_t p;
		reply_t none;
		none = '{default: '0};
		sel = $urandom_range(99);
		idx = 8'($urandom);
		i = int'(idx);
		if (sel < 25) send(ACT_INTERP, 8'($urandom), rnd_query(), rnd48(), 1'b0, none);
		else if (sel < 42) send(ACT_READ, idx, rnd48(), rnd48(), 1'b0, none);
		else if (sel < 57) send(ACT_READP, 8'($urandom), rnd_query(), rnd48(), 1'b0, none);
		else if (sel < 70) send(ACT_SETV, 8'($urandom), rnd_query(), rnd_value(), 1'b0, none);
		else if (sel < 93) begin
			p = grid_pos[i];
			if (i > 0 && i < NPTS - 1) begin
				lo = longint'(grid_pos[i - 1]);
				hi = longint'(grid_pos[i + 1]);
				if ($urandom_range(9) == 0) p = grid_pos[i - 1];
				else if (hi - lo > 1)
					p = num_t'(lo + 1 + longint'({$urandom, $urandom} % (hi - lo - 1)));
			end
			send(ACT_WRITE, idx, p, rnd_value(), 1'b0, none);
		end else if (sel < 95) send(ACT_WRITE, idx, rnd48(), rnd48(), 1'b0, none);
		else send(act_t'($urandom_range(7, 5)), 8'($urandom), rnd48(), rnd48(), 1'b0, none);
	endtask

	always @(posedge clk) begin
		reply_t w;
		if (out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: transfer with nothing pending: value %h loc %0d status %0d",
					$realtime, result_value, location, status);
			end else begin
				w = pending_q.pop_front();
				if (w.value !== result_value || w.loc !== location || w.st !== status) begin
					errors++;
					$display("%0t: mismatch exp value %h loc %0d status %0d, got %h %0d %0d",
						$realtime, w.value, w.loc, w.st, result_value, location, status);
				end
			end
		end
	end

	initial begin : rx_side
		int held_left;
		bit held;
		held_left = 0;
		held = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				held_left = 6000;
			end
			if (held_left > 0) begin
				held_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= $urandom_range(99) >= rcv_idle;
			end
		end
	end

	initial begin : main
		reply_t z;
		logic [3:0] orders [5];
		errors = 0;
		hold_req = 1'b0;
		snd_idle = 0;
		rcv_idle = 0;
		order_reg = 32'(ORDER_RST);
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		action = '0;
		point_index = '0;
		position = '0;
		point_value = '0;
		for (int i = 0; i < NPTS; i++) begin
			grid_pos[i] = '0;
			grid_val[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		z = '{default: '0};
		for (int i = 0; i < NPTS; i++)
			send(ACT_WRITE, 8'(i), fill_pos(i), rnd_value(), 1'b0, z);

		rows.push_back('{ACT_WRITE, 8'd0, NEG_MAX, POS_MAX, 1'b1, '{'0, 9'd0, 1'b0}});
		rows.push_back('{ACT_WRITE, 8'd255, POS_MAX - 1, NEG_MAX, 1'b1,
			'{'0, 9'd255, 1'b0}});
		rows.push_back('{ACT_SETV, 8'd0, POS_MAX, POS_MAX, 1'b1, '{'0, 9'd256, 1'b1}});
		rows.push_back('{ACT_READP, 8'd0, POS_MAX, '0, 1'b1, '{'0, 9'd256, 1'b1}});
		rows.push_back('{ACT_BAD5, 8'hff, POS_MAX, NEG_MAX, 1'b1, '{default: '0}});
		rows.push_back('{ACT_BAD6, 8'h55, rnd48(), rnd48(), 1'b1, '{default: '0}});
		rows.push_back('{ACT_BAD7, 8'haa, NEG_MAX, POS_MAX, 1'b1, '{default: '0}});
		rows.push_back('{ACT_READ, 8'd0, '0, '0, 1'b0, z});
		rows.push_back('{ACT_READ, 8'd255, '0, '0, 1'b0, z});
		rows.push_back('{ACT_READ, 8'd128, '0, '0, 1'b0, z});
		rows.push_back('{ACT_READP, 8'd0, NEG_MAX, '0, 1'b0, z});
		rows.push_back('{ACT_SETV, 8'd0, fill_pos(10), NEG_MAX, 1'b0, z});
		rows.push_back('{ACT_SETV, 8'd0, fill_pos(11) - 1, 48'sd1 <<< 24, 1'b0, z});
		rows.push_back('{ACT_READ, 8'd11, '0, '0, 1'b0, z});
		rows.push_back('{ACT_INTERP, 8'd0, NEG_MAX, '0, 1'b0, z});
		rows.push_back('{ACT_INTERP, 8'd0, POS_MAX - 1, '0, 1'b0, z});
		rows.push_back('{ACT_INTERP, 8'd0, POS_MAX, '0, 1'b0, z});
		rows.push_back('{ACT_INTERP, 8'd0, fill_pos(50), '0, 1'b0, z});
		rows.push_back('{ACT_INTERP, 8'd0, fill_pos(60) + 12345, '0, 1'b0, z});
		rows.push_back('{ACT_WRITE, 8'd101, fill_pos(100), 48'sd3 <<< 24, 1'b0, z});
		rows.push_back('{ACT_INTERP, 8'd0, fill_pos(100) + 777, '0, 1'b0, z});
		rows.push_back('{ACT_WRITE, 8'd101, fill_pos(101), -(48'sd5 <<< 24), 1'b0, z});
		rows.push_back('{ACT_INTERP, 8'd0, fill_pos(1) - 99, '0, 1'b0, z});
		foreach (rows[r])
			send(rows[r].act, rows[r].idx, rows[r].pos, rows[r].val, rows[r].typed,
				rows[r].want);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			snd_idle = (ph == 0) ? 16 : (ph == 1) ? 87 : 0;
			rcv_idle = (ph == 0) ? 87 : (ph == 1) ? 16 : 0;
			orders = '{4'd1, 4'd8, 4'd0, 4'd15, 4'($urandom_range(7, 2))};
			for (int s = 0; s < 5; s++) begin
				set_order(orders[s]);
				if (ph == 0 && s == 0) hold_req = 1'b1;
				repeat (32) random_item();
				drain();
			end
		end
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0)
			$display("grid_polynomial_interpolator regression: pass");
		else
			$display("grid_polynomial_interpolator regression: fail");
		$finish;
	end

endmodule
